### sv/stdtq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue - shared definitions
// Field widths, operation and status codes, and the command word that steers
// the row of queue cells.
// ----------------------------------------------------------------------------
package stdtq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 48;
  localparam int unsigned MAX_RESULTS     = 16;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned DELAY_W   = 32;
  localparam int unsigned HANDLE_W  = 4;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned WAIT_W    = 32;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned COUNT_MAX = 31;

  // delay, handle, tag, padded to whole bytes
  localparam int unsigned S_TDATA_W = 72;
  // handle, tag, wait, count, padded to whole bytes
  localparam int unsigned M_TDATA_W = 80;

  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 2'd0,
    OP_DEL_HANDLE = 2'd1,
    OP_DEL_TAG    = 2'd2,
    OP_TICK       = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE      = 3'd0,
    STS_FULL      = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_FIRED     = 3'd3,
    STS_NONE      = 3'd4
  } status_e;

  // Command broadcast to every cell of the queue
  typedef struct packed {
    logic insert;   // open a gap at the insertion point and fill it
    logic rm_head;  // drop the head, everything moves up one place
    logic rm_slot;  // drop the entry holding the key slot
    logic rm_tag;   // drop the first entry holding the key tag
  } cell_cmd_t;

endpackage

### sv/stdtq_cell.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue - queue cell
// Holds one position of the sorted list (deadline, tag, slot) and trades
// entries with its neighbours on insert and remove.
// ----------------------------------------------------------------------------
module stdtq_cell #(
  parameter int unsigned TIME_BITS = stdtq_pkg::TIME_BITS_DEF,
  parameter int unsigned SLOT_W    = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  stdtq_pkg::cell_cmd_t     cmd_i,
  input  logic [TIME_BITS-1:0]     new_dl_i,
  input  logic [stdtq_pkg::TAG_W-1:0] new_tag_i,
  input  logic [SLOT_W-1:0]        new_slot_i,
  input  logic [SLOT_W-1:0]        key_slot_i,
  input  logic [stdtq_pkg::TAG_W-1:0] key_tag_i,
  input  logic                     prev_vld_i,
  input  logic [TIME_BITS-1:0]     prev_dl_i,
  input  logic [stdtq_pkg::TAG_W-1:0] prev_tag_i,
  input  logic [SLOT_W-1:0]        prev_slot_i,
  input  logic                     prev_after_i,
  input  logic                     prev_hit_i,
  input  logic                     next_vld_i,
  input  logic [TIME_BITS-1:0]     next_dl_i,
  input  logic [stdtq_pkg::TAG_W-1:0] next_tag_i,
  input  logic [SLOT_W-1:0]        next_slot_i,
  output logic                     vld_o,
  output logic [TIME_BITS-1:0]     dl_o,
  output logic [stdtq_pkg::TAG_W-1:0] tag_o,
  output logic [SLOT_W-1:0]        slot_o,
  output logic                     after_o,
  output logic                     hit_o,
  output logic                     match_o
);
  import stdtq_pkg::*;

  logic               vld_q, vld_d;
  logic [TIME_BITS-1:0] dl_q, dl_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic               own_match;

  // An empty cell sits behind every queued entry, so it counts as after
  assign after_o   = !vld_q || (dl_q >= new_dl_i);
  assign own_match = vld_q && ((cmd_i.rm_slot && (slot_q == key_slot_i)) ||
                               (cmd_i.rm_tag && (tag_q == key_tag_i)));
  assign hit_o     = prev_hit_i || own_match;
  assign match_o   = own_match && !prev_hit_i;

  always_comb begin
    vld_d  = vld_q;
    dl_d   = dl_q;
    tag_d  = tag_q;
    slot_d = slot_q;
    if (cmd_i.insert) begin
      if (after_o && prev_after_i) begin
        vld_d  = prev_vld_i;
        dl_d   = prev_dl_i;
        tag_d  = prev_tag_i;
        slot_d = prev_slot_i;
      end else if (after_o) begin
        vld_d  = 1'b1;
        dl_d   = new_dl_i;
        tag_d  = new_tag_i;
        slot_d = new_slot_i;
      end
    end else if (cmd_i.rm_head || hit_o) begin
      // close the gap: take the entry behind
      vld_d  = next_vld_i;
      dl_d   = next_dl_i;
      tag_d  = next_tag_i;
      slot_d = next_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q   <= dl_d;
    tag_q  <= tag_d;
    slot_q <= slot_d;
  end

  assign vld_o  = vld_q;
  assign dl_o   = dl_q;
  assign tag_o  = tag_q;
  assign slot_o = slot_q;

endmodule

### sv/sorted_deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue
// One-shot timers kept in deadline order in a row of cells, with a millisecond
// counter that each tick advances, add, delete by handle or tag, and tick.
// ----------------------------------------------------------------------------
// Each request is taken only while the block is idle. An add or a delete
// goes through the accept step, one pass that updates the cell row, and the
// load of the output register; the next request is taken once the block is
// back to idle. A tick gives at least one result and at most MAX_RESULTS: the
// head cell is the only place a timer can fire from, so due timers leave one
// per pass of the row, each pass followed by the load of its result. A
// stalled output holds the block until the output register is free. There is
// no clearing pass after reset.
module sorted_deadline_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = stdtq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_BITS   = stdtq_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // delay_ms [31:0], slot_handle [35:32], client_tag [67:36], zero [71:68]
  input  logic [stdtq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // operation [1:0]
  input  logic [stdtq_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // result_handle [3:0], result_tag [35:4], wait_to_next_ms [67:36],
  // pending_count [72:68], zero [79:73]
  output logic [stdtq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // status [2:0]
  output logic [stdtq_pkg::STATUS_W-1:0]   m_axis_tuser,
  // last_result
  output logic                             m_axis_tlast
);
  import stdtq_pkg::*;

  localparam int unsigned SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FIRED_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_EMIT
  } state_e;

  // Control and request registers
  state_e               state_q;
  op_e                  op_q;
  logic [TIME_BITS-1:0] new_dl_q;
  logic [HANDLE_W-1:0]  op_handle_q;
  logic [TAG_W-1:0]     op_tag_q;
  logic [TIME_BITS-1:0] now_q;
  logic [CNT_W-1:0]     count_q;
  logic [QUEUE_DEPTH-1:0] slot_valid_q;
  logic [FIRED_W-1:0]   fired_q;

  // Result being formed
  status_e              res_status_q;
  logic [HANDLE_W-1:0]  res_handle_q;
  logic [TAG_W-1:0]     res_tag_q;

  // Output register
  logic                 m_valid_q;
  status_e              m_status_q;
  logic [HANDLE_W-1:0]  m_handle_q;
  logic [TAG_W-1:0]     m_tag_q;
  logic [WAIT_W-1:0]    m_wait_q;
  logic [COUNT_W-1:0]   m_count_q;
  logic                 m_last_q;

  // Cell row
  cell_cmd_t            cmd;
  logic [SLOT_W-1:0]    free_slot;
  logic [SLOT_W-1:0]    key_slot;
  logic                 handle_ok;
  logic                 full;
  logic [QUEUE_DEPTH-1:0] cell_vld, cell_after, cell_hit, cell_match;
  logic [TIME_BITS-1:0] cell_dl   [QUEUE_DEPTH];
  logic [TAG_W-1:0]     cell_tag  [QUEUE_DEPTH];
  logic [SLOT_W-1:0]    cell_slot [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] prev_vld, prev_after, prev_hit, next_vld;
  logic [TIME_BITS-1:0] prev_dl   [QUEUE_DEPTH];
  logic [TAG_W-1:0]     prev_tag  [QUEUE_DEPTH];
  logic [SLOT_W-1:0]    prev_slot [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] next_dl   [QUEUE_DEPTH];
  logic [TAG_W-1:0]     next_tag  [QUEUE_DEPTH];
  logic [SLOT_W-1:0]    next_slot [QUEUE_DEPTH];

  logic                 found;
  logic [TAG_W-1:0]     match_tag;
  logic [SLOT_W-1:0]    match_slot;
  logic                 head_due;
  logic [TIME_BITS-1:0] head_diff;
  logic [WAIT_W-1:0]    wait_ms;
  logic [COUNT_W-1:0]   count_sat;
  logic                 more;
  op_e                  in_op;

  assign in_op     = op_e'(s_axis_tuser);
  assign handle_ok = 32'(op_handle_q) < QUEUE_DEPTH;
  assign key_slot  = SLOT_W'(op_handle_q);
  assign full      = count_q >= CNT_W'(QUEUE_DEPTH);

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
      if (!slot_valid_q[k]) begin
        free_slot = SLOT_W'(k);
      end
    end
  end

  always_comb begin
    cmd = '0;
    case (state_q)
      ST_EXEC: begin
        case (op_q)
          OP_ADD:        cmd.insert  = !full;
          OP_DEL_HANDLE: cmd.rm_slot = handle_ok;
          OP_DEL_TAG:    cmd.rm_tag  = (op_tag_q != '0);
          default: ;
        endcase
      end
      ST_TICK: cmd.rm_head = head_due;
      default: ;
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_vld[i]   = 1'b0;
      assign prev_dl[i]    = '0;
      assign prev_tag[i]   = '0;
      assign prev_slot[i]  = '0;
      assign prev_after[i] = 1'b0;
      assign prev_hit[i]   = 1'b0;
    end else begin : g_mid
      assign prev_vld[i]   = cell_vld[i-1];
      assign prev_dl[i]    = cell_dl[i-1];
      assign prev_tag[i]   = cell_tag[i-1];
      assign prev_slot[i]  = cell_slot[i-1];
      assign prev_after[i] = cell_after[i-1];
      assign prev_hit[i]   = cell_hit[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_vld[i]  = 1'b0;
      assign next_dl[i]   = '0;
      assign next_tag[i]  = '0;
      assign next_slot[i] = '0;
    end else begin : g_inner
      assign next_vld[i]  = cell_vld[i+1];
      assign next_dl[i]   = cell_dl[i+1];
      assign next_tag[i]  = cell_tag[i+1];
      assign next_slot[i] = cell_slot[i+1];
    end

    stdtq_cell #(
      .TIME_BITS (TIME_BITS),
      .SLOT_W    (SLOT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .new_dl_i     (new_dl_q),
      .new_tag_i    (op_tag_q),
      .new_slot_i   (free_slot),
      .key_slot_i   (key_slot),
      .key_tag_i    (op_tag_q),
      .prev_vld_i   (prev_vld[i]),
      .prev_dl_i    (prev_dl[i]),
      .prev_tag_i   (prev_tag[i]),
      .prev_slot_i  (prev_slot[i]),
      .prev_after_i (prev_after[i]),
      .prev_hit_i   (prev_hit[i]),
      .next_vld_i   (next_vld[i]),
      .next_dl_i    (next_dl[i]),
      .next_tag_i   (next_tag[i]),
      .next_slot_i  (next_slot[i]),
      .vld_o        (cell_vld[i]),
      .dl_o         (cell_dl[i]),
      .tag_o        (cell_tag[i]),
      .slot_o       (cell_slot[i]),
      .after_o      (cell_after[i]),
      .hit_o        (cell_hit[i]),
      .match_o      (cell_match[i])
    );
  end

  assign found = cell_hit[QUEUE_DEPTH-1];

  // At most one cell matches first, so an OR picks its entry
  always_comb begin
    match_tag  = '0;
    match_slot = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      match_tag  = match_tag  | (cell_match[k] ? cell_tag[k]  : '0);
      match_slot = match_slot | (cell_match[k] ? cell_slot[k] : '0);
    end
  end

  assign head_due  = cell_vld[0] && (cell_dl[0] <= now_q);
  assign head_diff = cell_dl[0] - now_q;
  always_comb begin
    if (!cell_vld[0] || head_due) begin
      wait_ms = '0;
    end else if (|head_diff[TIME_BITS-1:WAIT_W]) begin
      wait_ms = '1;
    end else begin
      wait_ms = head_diff[WAIT_W-1:0];
    end
  end

  assign count_sat = (32'(count_q) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(count_q);
  assign more      = (op_q == OP_TICK) && head_due && (32'(fired_q) < MAX_RESULTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      now_q        <= '0;
      count_q      <= '0;
      slot_valid_q <= '0;
      fired_q      <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (m_axis_tready && (state_q != ST_EMIT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q        <= in_op;
            new_dl_q    <= now_q + TIME_BITS'(s_axis_tdata[DELAY_W-1:0]);
            op_handle_q <= s_axis_tdata[DELAY_W +: HANDLE_W];
            op_tag_q    <= s_axis_tdata[DELAY_W + HANDLE_W +: TAG_W];
            fired_q     <= '0;
            if (in_op == OP_TICK) begin
              now_q   <= now_q + TIME_BITS'(1);
              state_q <= ST_TICK;
            end else begin
              state_q <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          case (op_q)
            OP_ADD: begin
              if (full) begin
                res_status_q <= STS_FULL;
                res_handle_q <= '0;
                res_tag_q    <= '0;
              end else begin
                res_status_q <= STS_DONE;
                res_handle_q <= HANDLE_W'(free_slot);
                res_tag_q    <= op_tag_q;
                slot_valid_q[free_slot] <= 1'b1;
                count_q      <= count_q + CNT_W'(1);
              end
            end
            OP_DEL_HANDLE: begin
              res_handle_q <= op_handle_q;
              if (found) begin
                res_status_q <= STS_DONE;
                res_tag_q    <= match_tag;
                slot_valid_q[key_slot] <= 1'b0;
                count_q      <= count_q - CNT_W'(1);
              end else begin
                res_status_q <= STS_NOT_FOUND;
                res_tag_q    <= '0;
              end
            end
            default: begin
              if (found) begin
                res_status_q <= STS_DONE;
                res_handle_q <= HANDLE_W'(match_slot);
                res_tag_q    <= op_tag_q;
                slot_valid_q[match_slot] <= 1'b0;
                count_q      <= count_q - CNT_W'(1);
              end else begin
                res_status_q <= STS_NOT_FOUND;
                res_handle_q <= '0;
                res_tag_q    <= '0;
              end
            end
          endcase
          state_q <= ST_EMIT;
        end
        ST_TICK: begin
          if (head_due) begin
            res_status_q <= STS_FIRED;
            res_handle_q <= HANDLE_W'(cell_slot[0]);
            res_tag_q    <= cell_tag[0];
            slot_valid_q[cell_slot[0]] <= 1'b0;
            count_q      <= count_q - CNT_W'(1);
            fired_q      <= fired_q + FIRED_W'(1);
          end else begin
            res_status_q <= STS_NONE;
            res_handle_q <= '0;
            res_tag_q    <= '0;
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q  <= 1'b1;
            m_status_q <= res_status_q;
            m_handle_q <= res_handle_q;
            m_tag_q    <= res_tag_q;
            m_wait_q   <= wait_ms;
            m_count_q  <= count_sat;
            m_last_q   <= !more;
            state_q    <= more ? ST_TICK : ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {
    {(M_TDATA_W - HANDLE_W - TAG_W - WAIT_W - COUNT_W){1'b0}},
    m_count_q, m_wait_q, m_tag_q, m_handle_q
  };

  // The slot bitmap must agree with the count of queued timers
  a_count_matches_slots : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(slot_valid_q) == 32'(count_q)))
    else $error("slot bitmap disagrees with queued count");

  // Occupied cells form an unbroken run from the head and match the queued count
  a_cells_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (($countones(cell_vld) == 32'(count_q)) &&
     (((cell_vld + QUEUE_DEPTH'(1)) & cell_vld) == '0)))
    else $error("cell row has a gap or wrong occupancy");

  // A tick advances the counter by exactly one
  a_tick_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (in_op == OP_TICK)) |=>
      (now_q == $past(now_q) + TIME_BITS'(1)))
    else $error("tick did not advance the counter");

  // A fired timer was due when it left the head
  a_fired_due : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_TICK) && cmd.rm_head) |-> (cell_vld[0] && (cell_dl[0] <= now_q)))
    else $error("head removed before its deadline");

endmodule

### tb/sorted_deadline_timer_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted deadline timer queue - testbench
// Walks a short table of add, delete and tick requests, then random episodes:
// mixed traffic, bursts that fill the queue and tick the due timers out, and
// unshaped noise. A local model of the queue predicts each report, or a table
// row supplies it, and each report leaving the block is checked field by
// field in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_tb;
  import stdtq_pkg::*;

  localparam int unsigned SLOTS          = QUEUE_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS   = 185;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 60;

  typedef struct packed {
    status_e               status;
    logic [HANDLE_W-1:0]   handle;
    logic [TAG_W-1:0]      tag;
    logic [WAIT_W-1:0]     wait_ms;
    logic [COUNT_W-1:0]    pending;
    logic                  last;
  } timer_report_t;

  typedef struct packed {
    op_e                   op;
    logic [DELAY_W-1:0]    delay;
    logic [HANDLE_W-1:0]   handle;
    logic [TAG_W-1:0]      tag;
    logic                  typed;
    timer_report_t         want;
  } opening_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [OP_W-1:0]        s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   m_axis_tlast;

  sorted_deadline_timer_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the timer queue
  logic [TIME_BITS_DEF-1:0] clock_ms;
  logic [TIME_BITS_DEF-1:0] due_at    [SLOTS];
  logic [TAG_W-1:0]         owner_tag [SLOTS];
  bit                       slot_busy [SLOTS];
  logic [HANDLE_W-1:0]      queue_order [SLOTS];
  int unsigned              queued;

  timer_report_t  timer_reports[$];
  opening_row_t   opening_rows[$];
  int unsigned    accepted_requests;
  int unsigned    mismatch_count;
  int unsigned    ready_stall;
  bit             steady;

  function automatic logic [WAIT_W-1:0] head_wait();
    logic [TIME_BITS_DEF-1:0] head_due;
    logic [TIME_BITS_DEF-1:0] gap_ms;
    if (queued == 0) return '0;
    head_due = due_at[queue_order[0]];
    if (head_due <= clock_ms) return '0;
    gap_ms = head_due - clock_ms;
    return (gap_ms > 48'hFFFF_FFFF) ? '1 : gap_ms[WAIT_W-1:0];
  endfunction

  task automatic post_report(input status_e st, input logic [HANDLE_W-1:0] h,
                             input logic [TAG_W-1:0] t, input bit last);
    timer_report_t r;
    r.status  = st;
    r.handle  = h;
    r.tag     = t;
    r.wait_ms = head_wait();
    r.pending = (queued > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(queued);
    r.last    = last;
    timer_reports.push_back(r);
  endtask

  task automatic drop_entry(input int unsigned pos);
    slot_busy[queue_order[pos]] = 1'b0;
    for (int i = pos; i + 1 < queued; i++) queue_order[i] = queue_order[i + 1];
    queued--;
  endtask

  task automatic apply_timer_op(input op_e op, input logic [DELAY_W-1:0] delay,
                                input logic [HANDLE_W-1:0] handle,
                                input logic [TAG_W-1:0] tag);
    logic [TIME_BITS_DEF-1:0] deadline;
    logic [TAG_W-1:0]         hit_tag;
    int unsigned              slot;
    int unsigned              pos;
    int unsigned              fired;
    bit                       hit;
    bit                       more;
    hit = 1'b0;
    case (op)
      OP_ADD: begin
        if (queued >= SLOTS) begin
          post_report(STS_FULL, '0, '0, 1'b1);
        end else begin
          deadline = clock_ms + delay;
          slot = 0;
          while (slot < SLOTS && slot_busy[slot]) slot++;
          pos = 0;
          // a new entry goes ahead of equal deadlines
          while (pos < queued && due_at[queue_order[pos]] < deadline) pos++;
          for (int i = queued; i > pos; i--) queue_order[i] = queue_order[i - 1];
          queue_order[pos] = slot[HANDLE_W-1:0];
          due_at[slot]     = deadline;
          owner_tag[slot]  = tag;
          slot_busy[slot]  = 1'b1;
          queued++;
          post_report(STS_DONE, slot[HANDLE_W-1:0], tag, 1'b1);
        end
      end
      OP_DEL_HANDLE: begin
        if (slot_busy[handle]) begin
          for (pos = 0; pos < queued && !hit; pos++) begin
            if (queue_order[pos] == handle) begin
              hit_tag = owner_tag[handle];
              drop_entry(pos);
              post_report(STS_DONE, handle, hit_tag, 1'b1);
              hit = 1'b1;
            end
          end
        end
        if (!hit) post_report(STS_NOT_FOUND, handle, '0, 1'b1);
      end
      OP_DEL_TAG: begin
        if (tag != '0) begin
          for (pos = 0; pos < queued && !hit; pos++) begin
            slot = queue_order[pos];
            if (owner_tag[slot] == tag) begin
              drop_entry(pos);
              post_report(STS_DONE, slot[HANDLE_W-1:0], tag, 1'b1);
              hit = 1'b1;
            end
          end
        end
        if (!hit) post_report(STS_NOT_FOUND, '0, '0, 1'b1);
      end
      default: begin
        clock_ms = clock_ms + 1'b1;
        fired = 0;
        more = queued > 0 && due_at[queue_order[0]] <= clock_ms;
        while (more) begin
          slot = queue_order[0];
          drop_entry(0);
          fired++;
          more = fired < MAX_RESULTS && queued > 0 && due_at[queue_order[0]] <= clock_ms;
          post_report(STS_FIRED, slot[HANDLE_W-1:0], owner_tag[slot], !more);
        end
        if (fired == 0) post_report(STS_NONE, '0, '0, 1'b1);
      end
    endcase
  endtask

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_request(input op_e op, input logic [DELAY_W-1:0] delay,
                              input logic [HANDLE_W-1:0] handle,
                              input logic [TAG_W-1:0] tag,
                              input bit typed, input timer_report_t want);
    int unsigned gap;
    int unsigned queued_before;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, tag, handle, delay};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    queued_before = timer_reports.size();
    apply_timer_op(op, delay, handle, tag);
    if (typed) begin
      // replace the modelled report by the one written in the table
      while (timer_reports.size() > queued_before) void'(timer_reports.pop_back());
      timer_reports.push_back(want);
    end
    accepted_requests++;
  endtask

  function automatic logic [HANDLE_W-1:0] pick_queued_slot();
    logic [HANDLE_W-1:0] busy_list[$];
    for (int s = 0; s < SLOTS; s++) if (slot_busy[s]) busy_list.push_back(s[HANDLE_W-1:0]);
    if (busy_list.size() == 0) return HANDLE_W'($urandom_range(0, SLOTS - 1));
    return busy_list[$urandom_range(0, busy_list.size() - 1)];
  endfunction

  function automatic logic [DELAY_W-1:0] random_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 6);
    if (r < 85) return $urandom_range(7, 60);
    if (r < 95) return $urandom;
    return '1;
  endfunction

  function automatic logic [TAG_W-1:0] random_tag();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'h5A00_0000 + $urandom_range(0, 5);
  endfunction

  task automatic mixed_request();
    int unsigned r;
    int unsigned add_share;
    logic [TAG_W-1:0] tag;
    r = $urandom_range(0, 99);
    add_share = (queued < 8) ? 45 : 30;
    if (r < add_share) begin
      send_request(OP_ADD, random_delay(), HANDLE_W'($urandom), random_tag(), 1'b0, '0);
    end else if (r < add_share + 20) begin
      send_request(OP_DEL_HANDLE, $urandom,
                   ($urandom_range(0, 9) < 6) ? pick_queued_slot() : HANDLE_W'($urandom),
                   $urandom, 1'b0, '0);
    end else if (r < add_share + 35) begin
      r = $urandom_range(0, 99);
      if (r < 60)      tag = owner_tag[pick_queued_slot()];
      else if (r < 85) tag = random_tag();
      else if (r < 95) tag = '0;
      else             tag = $urandom;
      send_request(OP_DEL_TAG, $urandom, HANDLE_W'($urandom), tag, 1'b0, '0);
    end else begin
      send_request(OP_TICK, $urandom, HANDLE_W'($urandom), $urandom, 1'b0, '0);
    end
  endtask

  task automatic add_row(input op_e op, input logic [DELAY_W-1:0] delay,
                         input logic [HANDLE_W-1:0] handle, input logic [TAG_W-1:0] tag,
                         input bit typed, input status_e st, input logic [HANDLE_W-1:0] h,
                         input logic [TAG_W-1:0] t, input logic [WAIT_W-1:0] w,
                         input logic [COUNT_W-1:0] c);
    opening_row_t row;
    row.op     = op;
    row.delay  = delay;
    row.handle = handle;
    row.tag    = tag;
    row.typed  = typed;
    row.want   = '{status: st, handle: h, tag: t, wait_ms: w, pending: c, last: 1'b1};
    opening_rows.push_back(row);
  endtask

  initial begin
    clock_ms = '0;
    queued   = 0;
    for (int s = 0; s < SLOTS; s++) begin
      due_at[s]      = '0;
      owner_tag[s]   = '0;
      slot_busy[s]   = 1'b0;
      queue_order[s] = '0;
    end
    accepted_requests = 0;
    mismatch_count    = 0;
    ready_stall       = 0;
    steady            = 1'b0;

    // empty queue: tick, unknown handle, zero tag
    add_row(OP_TICK, '0, '0, '0, 1'b1, STS_NONE, '0, '0, '0, 5'd0);
    add_row(OP_DEL_HANDLE, '0, 4'd5, '0, 1'b1, STS_NOT_FOUND, 4'd5, '0, '0, 5'd0);
    add_row(OP_DEL_TAG, '1, '1, '0, 1'b1, STS_NOT_FOUND, '0, '0, '0, 5'd0);
    // longest delay, then one already due that goes to the head
    add_row(OP_ADD, '1, '0, '1, 1'b1, STS_DONE, 4'd0, '1, '1, 5'd1);
    add_row(OP_ADD, '0, '0, 32'd1, 1'b1, STS_DONE, 4'd1, 32'd1, '0, 5'd2);
    // fill with equal deadlines and repeated tags
    for (int i = 0; i < 14; i++)
      add_row(OP_ADD, 32'd3, '0, 32'h5A00_0000 + (i % 5), 1'b0, STS_DONE, '0, '0, '0, '0);
    add_row(OP_ADD, 32'd7, '0, 32'hDEAD_0001, 1'b1, STS_FULL, '0, '0, '0, 5'd16);
    add_row(OP_DEL_HANDLE, '0, 4'd15, '0, 1'b0, STS_DONE, '0, '0, '0, '0);
    add_row(OP_DEL_TAG, '0, '0, 32'h5A00_0002, 1'b0, STS_DONE, '0, '0, '0, '0);
    // one fires, nothing due, then the whole group at once
    repeat (3) add_row(OP_TICK, '0, '0, '0, 1'b0, STS_DONE, '0, '0, '0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[i])
      send_request(opening_rows[i].op, opening_rows[i].delay, opening_rows[i].handle,
                   opening_rows[i].tag, opening_rows[i].typed, opening_rows[i].want);

    while (accepted_requests < opening_rows.size() + RANDOM_ITEMS) begin
      int unsigned kind;
      int unsigned common_delay;
      kind   = $urandom_range(0, 99);
      steady = ($urandom_range(0, 3) == 0);
      if (kind < 60) begin
        repeat (8) mixed_request();
      end else if (kind < 85) begin
        // fill to the brim, one add past it, then tick the due ones out
        common_delay = $urandom_range(0, 3);
        while (queued < SLOTS)
          send_request(OP_ADD, $urandom_range(0, 1) ? common_delay : random_delay(),
                       HANDLE_W'($urandom), random_tag(), 1'b0, '0);
        send_request(OP_ADD, random_delay(), HANDLE_W'($urandom), random_tag(), 1'b0, '0);
        repeat ($urandom_range(2, 6))
          send_request(OP_TICK, $urandom, HANDLE_W'($urandom), $urandom, 1'b0, '0);
      end else begin
        repeat (6)
          send_request(op_e'($urandom_range(0, 3)), $urandom, HANDLE_W'($urandom),
                       $urandom, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    while (timer_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Report side: check each accepted report, then pick the next ready level
  always @(posedge clk_i) begin : report_check
    timer_report_t want;
    timer_report_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status  = status_e'(m_axis_tuser);
      got.handle  = m_axis_tdata[3:0];
      got.tag     = m_axis_tdata[35:4];
      got.wait_ms = m_axis_tdata[67:36];
      got.pending = m_axis_tdata[72:68];
      got.last    = m_axis_tlast;
      if (timer_reports.size() == 0) begin
        $error("report with none pending: status %0d handle %0d", got.status, got.handle);
        mismatch_count++;
      end else begin
        want = timer_reports.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          mismatch_count++;
        end
        if (got.handle !== want.handle) begin
          $error("result_handle: expected %0d, got %0d", want.handle, got.handle);
          mismatch_count++;
        end
        if (got.tag !== want.tag) begin
          $error("result_tag: expected %h, got %h", want.tag, got.tag);
          mismatch_count++;
        end
        if (got.wait_ms !== want.wait_ms) begin
          $error("wait_to_next_ms: expected %0d, got %0d", want.wait_ms, got.wait_ms);
          mismatch_count++;
        end
        if (got.pending !== want.pending) begin
          $error("pending_count: expected %0d, got %0d", want.pending, got.pending);
          mismatch_count++;
        end
        if (got.last !== want.last) begin
          $error("last_result: expected %0d, got %0d", want.last, got.last);
          mismatch_count++;
        end
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (ready_stall > 0) begin
      ready_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 20) ready_stall = idle_len();
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### files.f
sv/stdtq_pkg.sv
sv/stdtq_cell.sv
sv/sorted_deadline_timer_queue.sv
tb/sorted_deadline_timer_queue_tb.sv
